@@ design/sfd_pkg.sv @@
// Shared constants and types for the stereo feedback delay.
// Used by the channel datapath and the top level; depends on nothing.
package sfd_pkg;

  localparam int DELAY_W    = 16;
  localparam int FB_W       = 15;
  localparam int MIX_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam int FB_MAX     = 32735;
  localparam int MIX_ONE    = 32768;

  localparam int DELAY_RST  = 24000;
  localparam int FB_RST     = 16384;
  localparam int MIX_RST    = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_MIX      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic rd_en;
    logic a_adv;
    logic p_adv;
    logic sel_fwd;
    logic sel_zero;
  } sfd_ctrl_t;

endpackage

@@ design/stereo_feedback_delay.sv @@
// Stereo feedback delay: configuration registers, write pointer, fill count
// and pipeline control around two channel datapaths.
// Depends on sfd_pkg, sfd_chan and sfd_ram.
//
// Usage: each input beat carries one stereo frame and yields exactly one
// output beat with the mixed left and right samples. Both channels use a
// valid/stall handshake; a beat moves when valid is high and stall is low.
// The pipeline has three stages: the store read, the feedback write-back
// with the mix products, and the output register. One beat can be accepted
// every cycle while the receiver does not stall; the loop through the
// feedback multiplier and the write-back to the store sets that rate, since
// a delay of one frame forwards each stored sample straight into the next
// beat. Configuration must be written through a plain write port only while
// no beat is in flight; the block does not enforce this. At reset the
// registers take their default values and the stores read as silence: a
// fill count marks which entries have been written, so no clearing pass is
// needed and beats are accepted from the first cycle.
// When the receiver stalls, the output register holds its beat and the
// stall ripples back only as far as the stages that are full.
module stereo_feedback_delay
  import sfd_pkg::*;
#(
  parameter int BUFFER_FRAMES = 65536,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  localparam int AW     = $clog2(BUFFER_FRAMES);
  localparam int FILL_W = AW + 1;
  localparam int CW     = (AW + 1 > DELAY_W + 1) ? AW + 1 : DELAY_W + 1;

  logic [DELAY_W-1:0] delay_q;
  logic [FB_W-1:0]    fb_q;
  logic [MIX_W-1:0]   mix_q;

  logic [AW-1:0]      wr_q;
  logic [AW-1:0]      wr_d;
  logic [AW-1:0]      a_wr_q;
  logic [AW-1:0]      a_rd_q;
  logic               a_unwr_q;
  logic [AW-1:0]      lw_addr_q;
  logic               lw_valid_q;
  logic [FILL_W-1:0]  fill_q;
  logic [FILL_W-1:0]  fill_d;

  logic               a_valid_q, a_valid_d;
  logic               p_valid_q, p_valid_d;
  logic               o_valid_q, o_valid_d;

  logic               o_free, p_free, a_free, accept;
  logic [AW-1:0]      d_eff;
  logic [AW:0]        rd_sum;
  logic [AW-1:0]      rd_addr;
  logic [FB_W-1:0]    fb_eff;
  logic [MIX_W-1:0]   mix_eff;
  logic [MIX_W-1:0]   mix_inv;
  sfd_ctrl_t          ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_W'(DELAY_RST);
      fb_q    <= FB_W'(FB_RST);
      mix_q   <= MIX_W'(MIX_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY:    delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_FEEDBACK: fb_q    <= cfg_data_i[FB_W-1:0];
        CFG_MIX:      mix_q   <= cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (delay_q == '0) begin
      d_eff = AW'(1);
    end else if (CW'(delay_q) >= CW'(BUFFER_FRAMES)) begin
      d_eff = AW'(BUFFER_FRAMES - 1);
    end else begin
      d_eff = AW'(delay_q);
    end
  end

  assign rd_sum  = {1'b0, wr_q} + (AW+1)'(BUFFER_FRAMES) - {1'b0, d_eff};
  assign rd_addr = (rd_sum >= (AW+1)'(BUFFER_FRAMES))
                 ? AW'(rd_sum - (AW+1)'(BUFFER_FRAMES)) : rd_sum[AW-1:0];

  assign fb_eff  = (fb_q > FB_W'(FB_MAX)) ? FB_W'(FB_MAX) : fb_q;
  assign mix_eff = (mix_q > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : mix_q;
  assign mix_inv = MIX_W'(MIX_ONE) - mix_eff;

  assign o_free     = !o_valid_q || !out_stall_i;
  assign p_free     = !p_valid_q || o_free;
  assign a_free     = !a_valid_q || p_free;
  assign in_stall_o = !a_free;
  assign accept     = in_valid_i && a_free;

  assign ctrl.rd_en    = accept;
  assign ctrl.a_adv    = a_valid_q && p_free;
  assign ctrl.p_adv    = p_valid_q && o_free;
  assign ctrl.sel_fwd  = lw_valid_q && (lw_addr_q == a_rd_q);
  assign ctrl.sel_zero = a_unwr_q;

  always_comb begin
    a_valid_d = a_valid_q;
    p_valid_d = p_valid_q;
    o_valid_d = o_valid_q;
    if (ctrl.a_adv) begin
      a_valid_d = 1'b0;
    end
    if (accept) begin
      a_valid_d = 1'b1;
    end
    if (ctrl.p_adv) begin
      p_valid_d = 1'b0;
    end
    if (ctrl.a_adv) begin
      p_valid_d = 1'b1;
    end
    if (o_valid_q && !out_stall_i) begin
      o_valid_d = 1'b0;
    end
    if (ctrl.p_adv) begin
      o_valid_d = 1'b1;
    end
  end

  assign wr_d   = (wr_q == AW'(BUFFER_FRAMES - 1)) ? '0 : wr_q + 1'b1;
  assign fill_d = (fill_q == FILL_W'(BUFFER_FRAMES)) ? fill_q : fill_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      p_valid_q  <= 1'b0;
      o_valid_q  <= 1'b0;
      wr_q       <= '0;
      a_wr_q     <= '0;
      a_rd_q     <= '0;
      a_unwr_q   <= 1'b0;
      lw_valid_q <= 1'b0;
      lw_addr_q  <= '0;
      fill_q     <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
      if (accept) begin
        wr_q     <= wr_d;
        a_wr_q   <= wr_q;
        a_rd_q   <= rd_addr;
        a_unwr_q <= ({1'b0, rd_addr} >= fill_q);
      end
      if (ctrl.a_adv) begin
        lw_valid_q <= 1'b1;
        lw_addr_q  <= a_wr_q;
        fill_q     <= fill_d;
      end
    end
  end

  sfd_chan #(
    .BUFFER_FRAMES(BUFFER_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_left (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(a_wr_q),
    .sample_i (left_in_i),
    .fb_gain_i(fb_eff),
    .mix_i    (mix_eff),
    .mix_inv_i(mix_inv),
    .sample_o (left_out_o)
  );

  sfd_chan #(
    .BUFFER_FRAMES(BUFFER_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_right (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(a_wr_q),
    .sample_i (right_in_i),
    .fb_gain_i(fb_eff),
    .mix_i    (mix_eff),
    .mix_inv_i(mix_inv),
    .sample_o (right_out_o)
  );

  assign out_valid_o = o_valid_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(BUFFER_FRAMES))
    else $error("fill count beyond the store depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.a_adv && fill_q != FILL_W'(BUFFER_FRAMES)) |=> fill_q == $past(fill_d))
    else $error("fill count missed a write-back");

  a_accept_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (a_valid_q && a_wr_q == $past(wr_q)))
    else $error("accepted beat did not take the write pointer");

  a_fwd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.a_adv |=> (lw_valid_q && lw_addr_q == $past(a_wr_q)))
    else $error("forwarding address does not follow the write-back");

endmodule

@@ design/sfd_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/sfd_chan.sv @@
// One channel of the delay: its sample store, the feedback write-back with
// forwarding, and the dry/wet blend. Depends on sfd_pkg and sfd_ram.
module sfd_chan
  import sfd_pkg::*;
#(
  parameter int BUFFER_FRAMES = 65536,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                                  clk_i,
  input  sfd_ctrl_t                             ctrl_i,
  input  logic [$clog2(BUFFER_FRAMES)-1:0]      rd_addr_i,
  input  logic [$clog2(BUFFER_FRAMES)-1:0]      wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic [FB_W-1:0]                       fb_gain_i,
  input  logic [MIX_W-1:0]                      mix_i,
  input  logic [MIX_W-1:0]                      mix_inv_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_o
);

  localparam int S = SAMPLE_BITS;
  localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};

  logic [S-1:0]          mem_rd;
  logic signed [S-1:0]   a_x_q;
  logic signed [S-1:0]   fwd_q;
  logic signed [S-1:0]   dly;
  logic signed [S+15:0]  fb_prod;
  logic signed [S+15:0]  fb_rnd;
  logic signed [S:0]     fb_term;
  logic signed [S+1:0]   fb_sum;
  logic signed [S-1:0]   fb_sat;
  logic signed [S+16:0]  dry_prod;
  logic signed [S+16:0]  wet_prod;
  logic signed [S+16:0]  dry_q;
  logic signed [S+16:0]  wet_q;
  logic signed [S+17:0]  mix_sum;
  logic signed [S+2:0]   mix_rnd;
  logic signed [S-1:0]   mix_sat;
  logic signed [S-1:0]   out_q;

  sfd_ram #(
    .WIDTH(S),
    .DEPTH(BUFFER_FRAMES)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (ctrl_i.a_adv),
    .wr_addr_i(wr_addr_i),
    .wr_data_i(fb_sat),
    .rd_en_i  (ctrl_i.rd_en),
    .rd_addr_i(rd_addr_i),
    .rd_data_o(mem_rd)
  );

  // The last write may have landed on the same edge as this beat's read.
  always_comb begin
    if (ctrl_i.sel_fwd) begin
      dly = fwd_q;
    end else if (ctrl_i.sel_zero) begin
      dly = '0;
    end else begin
      dly = $signed(mem_rd);
    end
  end

  assign fb_prod = dly * $signed({1'b0, fb_gain_i});
  assign fb_rnd  = fb_prod + (S+16)'(ROUND_HALF);
  assign fb_term = fb_rnd[S+15:FRAC_BITS];
  assign fb_sum  = (S+2)'(a_x_q) + (S+2)'(fb_term);

  always_comb begin
    if (fb_sum > (S+2)'(SMAX)) begin
      fb_sat = SMAX;
    end else if (fb_sum < (S+2)'(SMIN)) begin
      fb_sat = SMIN;
    end else begin
      fb_sat = fb_sum[S-1:0];
    end
  end

  assign dry_prod = a_x_q * $signed({1'b0, mix_inv_i});
  assign wet_prod = dly * $signed({1'b0, mix_i});

  assign mix_sum = (S+18)'(dry_q) + (S+18)'(wet_q) + (S+18)'(ROUND_HALF);
  assign mix_rnd = mix_sum[S+17:FRAC_BITS];

  always_comb begin
    if (mix_rnd > (S+3)'(SMAX)) begin
      mix_sat = SMAX;
    end else if (mix_rnd < (S+3)'(SMIN)) begin
      mix_sat = SMIN;
    end else begin
      mix_sat = mix_rnd[S-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      a_x_q <= sample_i;
    end
    if (ctrl_i.a_adv) begin
      fwd_q <= fb_sat;
      dry_q <= dry_prod;
      wet_q <= wet_prod;
    end
    if (ctrl_i.p_adv) begin
      out_q <= mix_sat;
    end
  end

  assign sample_o = out_q;

endmodule

@@ tb/tb_stereo_feedback_delay.sv @@
// Self-checking testbench for stereo_feedback_delay: directed and random beats
// are checked against a cycle-free model of the echo kept in a scoreboard class.
// Depends on sfd_pkg and the stereo_feedback_delay RTL.
module tb_stereo_feedback_delay
  import sfd_pkg::*;
();

  localparam int SW          = 16;
  localparam int BUF_FRAMES  = 65536;
  localparam int SMAX        = (1 << (SW - 1)) - 1;
  localparam int LATENCY     = 3;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 36;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } frame_t;

  class echo_delay_calc;
    bit signed [SW-1:0] left_mem [BUF_FRAMES];
    bit signed [SW-1:0] right_mem [BUF_FRAMES];
    int unsigned wr_ptr;
    int unsigned delay_reg;
    int unsigned fb_reg;
    int unsigned mix_reg;
    frame_t pending_frames[$];
    int errors;

    function new();
      wr_ptr    = 0;
      delay_reg = DELAY_RST;
      fb_reg    = FB_RST;
      mix_reg   = MIX_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DELAY: begin
          delay_reg = 32'(val);
        end
        CFG_FEEDBACK: begin
          fb_reg = 32'(val[FB_W-1:0]);
        end
        CFG_MIX: begin
          mix_reg = 32'(val);
        end
        default: begin
        end
      endcase
    endfunction

    function longint clip(longint v);
      if (v > SMAX) return SMAX;
      if (v < -SMAX - 1) return -SMAX - 1;
      return v;
    endfunction

    function longint q15_round(longint p);
      return (p + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function void echo_channel(input longint x, input longint d, input longint fb,
                               input longint mix, output longint stored,
                               output longint y);
      stored = clip(x + q15_round(d * fb));
      y      = clip(q15_round((MIX_ONE - mix) * x + mix * d));
    endfunction

    function void take_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
      int unsigned dly;
      int unsigned fb;
      int unsigned mix;
      int unsigned rd;
      longint ls;
      longint rs;
      longint lo;
      longint ro;
      frame_t f;
      dly = delay_reg;
      if (dly == 0) dly = 1;
      if (dly >= BUF_FRAMES) dly = BUF_FRAMES - 1;
      fb  = (fb_reg > FB_MAX) ? FB_MAX : fb_reg;
      mix = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
      rd  = (wr_ptr + BUF_FRAMES - dly) % BUF_FRAMES;
      echo_channel(l, left_mem[rd], fb, mix, ls, lo);
      echo_channel(r, right_mem[rd], fb, mix, rs, ro);
      left_mem[wr_ptr]  = SW'(ls);
      right_mem[wr_ptr] = SW'(rs);
      wr_ptr = (wr_ptr + 1) % BUF_FRAMES;
      f.left  = SW'(lo);
      f.right = SW'(ro);
      pending_frames = {pending_frames, f};
    endfunction

    function void match_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
      frame_t f;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual left %0d right %0d",
                 $time, l, r);
        errors++;
        return;
      end
      f = pending_frames.pop_front();
      if (l !== f.left) begin
        $display("%0t: left_out mismatch, expected %0d, actual %0d", $time, f.left, l);
        errors++;
      end
      if (r !== f.right) begin
        $display("%0t: right_out mismatch, expected %0d, actual %0d", $time, f.right, r);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [SW-1:0]  left_in_i;
  logic signed [SW-1:0]  right_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [SW-1:0]  left_out_o;
  logic signed [SW-1:0]  right_out_o;

  int idle_pct;
  int stall_pct;
  int hold_requests;
  int hold_served;

  echo_delay_calc echo = new();

  stereo_feedback_delay #(
    .BUFFER_FRAMES(BUF_FRAMES),
    .SAMPLE_BITS  (SW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .left_in_i  (left_in_i),
    .right_in_i (right_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .left_out_o (left_out_o),
    .right_out_o(right_out_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      echo.match_frame(left_out_o, right_out_o);
    end
  end

  // The long hold-off is counted here so that the sender keeps offering beats.
  initial begin
    out_stall_i = 1'b0;
    hold_served = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return SW'($urandom_range(0, 15) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    echo.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    echo.take_frame(l, r);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (echo.pending_frames.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 1) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DELAY;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    left_in_i     = '0;
    right_in_i    = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values of the registers, store reads as silence.
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0001, 16'shffff);

    // Zero delay, over-range feedback and mix: the store saturates.
    settle();
    write_reg(CFG_DELAY, 16'h0000);
    write_reg(CFG_FEEDBACK, 16'hffff);
    write_reg(CFG_MIX, 16'hffff);
    repeat (3) send_frame(16'sh7fff, 16'sh8000);
    repeat (3) send_frame(16'sh8000, 16'sh7fff);

    // Longest delay with no feedback and a fully dry output.
    settle();
    write_reg(CFG_DELAY, 16'hffff);
    write_reg(CFG_FEEDBACK, 16'h0000);
    write_reg(CFG_MIX, 16'h0000);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'shffff, 16'sh0001);

    // A write to an unused index must leave the registers alone.
    settle();
    write_reg(CFG_UNUSED, 16'h1234);
    send_frame(16'sh4000, 16'shc000);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh0003, 16'shfffd);

    settle();
    write_reg(CFG_DELAY, 16'd2);
    write_reg(CFG_FEEDBACK, CFG_DATA_W'(FB_MAX));
    write_reg(CFG_MIX, CFG_DATA_W'(MIX_ONE));
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh1234, 16'shedcb);
    send_frame(16'sh0001, 16'shffff);

    settle();
    write_reg(CFG_DELAY, 16'd3);
    write_reg(CFG_FEEDBACK, CFG_DATA_W'(FB_MAX + 1));
    write_reg(CFG_MIX, CFG_DATA_W'(MIX_ONE + 1));
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh2000, 16'she000);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(9))
        0: write_reg(CFG_DELAY, 16'h0000);
        1: write_reg(CFG_DELAY, 16'hffff);
        2: write_reg(CFG_DELAY, CFG_DATA_W'($urandom_range(17, 500)));
        3: write_reg(CFG_DELAY, CFG_DATA_W'($urandom));
        default: write_reg(CFG_DELAY, CFG_DATA_W'($urandom_range(1, 16)));
      endcase
      case ($urandom_range(5))
        0: write_reg(CFG_FEEDBACK, 16'h0000);
        1: write_reg(CFG_FEEDBACK, CFG_DATA_W'(FB_MAX));
        2: write_reg(CFG_FEEDBACK, 16'hffff);
        default: write_reg(CFG_FEEDBACK, CFG_DATA_W'($urandom));
      endcase
      case ($urandom_range(5))
        0: write_reg(CFG_MIX, 16'h0000);
        1: write_reg(CFG_MIX, CFG_DATA_W'(MIX_ONE));
        2: write_reg(CFG_MIX, CFG_DATA_W'($urandom));
        default: write_reg(CFG_MIX, CFG_DATA_W'($urandom_range(0, MIX_ONE)));
      endcase
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      if (ph == 4) begin
        hold_requests++;
      end
      repeat (PHASE_BEATS) send_frame(rand_sample(), rand_sample());
    end

    settle();
    repeat (LATENCY + 5) @(negedge clk_i);
    if (echo.errors == 0 && echo.pending_frames.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
